// ===== rtl/core/macd_indicator_engine_defines.svh =====
// Assertion macros for the MACD indicator engine.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef MACD_INDICATOR_ENGINE_DEFINES_SVH
`define MACD_INDICATOR_ENGINE_DEFINES_SVH

// same-cycle implication
`define MACD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MACD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/macd_pkg.sv =====
// Shared types and constants of the MACD indicator engine.
// No dependencies.
`default_nettype none
package macd_pkg;

    localparam int PRICE_W = 32;
    localparam int SUM_W   = PRICE_W + 8;
    localparam int NUM_W   = PRICE_W + 11;
    localparam int DIV_W   = NUM_W - 1;
    localparam int DEN_W   = 10;
    localparam int IDX_W   = 16;
    localparam int CNT_W   = $clog2(DIV_W);
    localparam int DAYS_W  = 8;
    localparam int ADDR_W  = 2;

    localparam logic [ADDR_W-1:0] CFG_FAST_DAYS   = 2'd0;
    localparam logic [ADDR_W-1:0] CFG_SLOW_DAYS   = 2'd1;
    localparam logic [ADDR_W-1:0] CFG_SIGNAL_DAYS = 2'd2;

    localparam logic [DAYS_W-1:0] FAST_DAYS_RST   = 8'd12;
    localparam logic [DAYS_W-1:0] SLOW_DAYS_RST   = 8'd26;
    localparam logic [DAYS_W-1:0] SIGNAL_DAYS_RST = 8'd9;

    typedef struct packed {
        logic [PRICE_W-1:0] close_price;
        logic               series_start;
    } in_item_t;

    typedef struct packed {
        logic [PRICE_W-1:0]        fast_average;
        logic                      fast_valid;
        logic [PRICE_W-1:0]        slow_average;
        logic                      slow_valid;
        logic signed [PRICE_W-1:0] macd_value;
        logic signed [PRICE_W-1:0] signal_value;
        logic                      signal_valid;
    } out_item_t;

    typedef enum logic [1:0] {
        UNIT_FAST,
        UNIT_SLOW,
        UNIT_SIG
    } unit_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_START,
        ST_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic  load;
        logic  mul;
        logic  div_start;
        logic  write;
        logic  emit;
        unit_t unit;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_full;
    } status_t;

endpackage
`default_nettype wire

// ===== rtl/core/macd_indicator_engine.sv =====
// MACD indicator engine, top level: sequencer plus datapath.
// Depends on macd_pkg, macd_ctrl, macd_dp and macd_indicator_engine_defines.svh.
//
// Usage:
//  - s_ channel carries one closing price (unsigned Q16.16) and a series_start
//    flag per transfer; series_start clears all running averages first.
//  - m_ channel returns one result per price: fast and slow EMA, MACD and
//    signal line with their valid flags; fields not yet valid read as zero.
//  - cfg_wr_en/cfg_addr/cfg_wr_data write the three periods (fast, slow,
//    signal), one per write; write them only while the engine is idle.
//    A period of zero acts as one. Unknown addresses are ignored.
//  - One price is processed at a time. Each of the three averages passes a
//    multiply state and a setup state, plus the shared bit-serial divider
//    when it seeds or updates; during warm-up the divider is skipped.
//  - Results sit in an output register; the next price is taken while a
//    result still waits, and the engine holds before writing the next result
//    until the receiver takes the previous one.
//  - Reset (aresetn low, synchronous) restores periods 12/26/9 and clears the
//    series; no output is pending after reset.
`default_nettype none
`include "macd_indicator_engine_defines.svh"
module macd_indicator_engine (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [macd_pkg::ADDR_W-1:0]  cfg_addr,
    input  wire logic [macd_pkg::DAYS_W-1:0]  cfg_wr_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire macd_pkg::in_item_t           s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output macd_pkg::out_item_t               m_data
);
    import macd_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: one command per cycle
    macd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // state, arithmetic and output register
    macd_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_data      (m_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .status      (status)
    );

    // one price in flight: no transfer right after another
    `MACD_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "second price taken while busy")
    // signal line only exists once both averages do
    `MACD_ASSERT_NOW(a_signal_needs_emas, m_valid && m_data.signal_valid, m_data.fast_valid && m_data.slow_valid, "signal valid before EMAs")
    // without a slow EMA there is no MACD
    `MACD_ASSERT_NOW(a_macd_zero, m_valid && !m_data.slow_valid, m_data.macd_value == '0 && m_data.slow_average == '0, "MACD nonzero before slow EMA")

endmodule
`default_nettype wire

// ===== rtl/core/macd_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on macd_pkg.
`default_nettype none
module macd_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [macd_pkg::DIV_W-1:0]  dividend,
    input  wire logic [macd_pkg::DEN_W-1:0]  divisor,
    output logic                             done,
    output logic [macd_pkg::DIV_W-1:0]       quotient
);
    import macd_pkg::*;

    logic [DIV_W-1:0] dvd_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             ge;

    always_comb begin
        rem_sh  = {rem_reg, dvd_reg[DIV_W-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        ge      = rem_sh >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule
`default_nettype wire

// ===== rtl/core/macd_ctrl.sv =====
// Sequencer of the MACD engine: walks fast, slow and signal averages in turn.
// Depends on macd_pkg.
`default_nettype none
module macd_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire macd_pkg::status_t status,
    output macd_pkg::cmd_t         cmd
);
    import macd_pkg::*;

    state_t state_reg, state_next;
    unit_t  unit_reg, unit_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            unit_reg  <= UNIT_FAST;
        end else begin
            state_reg <= state_next;
            unit_reg  <= unit_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        unit_next     = unit_reg;
        cmd           = '0;
        cmd.unit      = unit_reg;
        s_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    unit_next  = UNIT_FAST;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_START;
            end
            ST_START: begin
                if (status.need_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_WAIT;
                end else if (unit_reg == UNIT_SIG) begin
                    state_next = ST_OUT;
                end else begin
                    unit_next  = (unit_reg == UNIT_FAST) ? UNIT_SLOW : UNIT_SIG;
                    state_next = ST_MUL;
                end
            end
            ST_WAIT: begin
                if (status.div_done) begin
                    cmd.write = 1'b1;
                    if (unit_reg == UNIT_SIG) begin
                        state_next = ST_OUT;
                    end else begin
                        unit_next  = (unit_reg == UNIT_FAST) ? UNIT_SLOW : UNIT_SIG;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_OUT: begin
                if (!status.out_full) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/macd_dp.sv =====
// Datapath of the MACD engine: series state, multiplier, divider, output register.
// Depends on macd_pkg and macd_div.
`default_nettype none
module macd_dp (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [macd_pkg::ADDR_W-1:0]  cfg_addr,
    input  wire logic [macd_pkg::DAYS_W-1:0]  cfg_wr_data,
    input  wire macd_pkg::in_item_t           s_data,
    output macd_pkg::out_item_t               m_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    input  wire macd_pkg::cmd_t               cmd,
    output macd_pkg::status_t                 status
);
    import macd_pkg::*;

    logic [DAYS_W-1:0] fast_days_reg, slow_days_reg, signal_days_reg;
    logic [IDX_W-1:0]  index_reg;
    logic [SUM_W-1:0]  fast_sum_reg, slow_sum_reg, macd_sum_reg;
    logic [PRICE_W-1:0] fast_ema_reg, slow_ema_reg, signal_ema_reg, price_reg;
    logic signed [41:0] prod_reg;
    logic               neg_reg;
    out_item_t          out_reg;
    logic               out_valid_reg;

    logic [DAYS_W-1:0]  fd, sd, gd, ms, n_sel;
    logic [IDX_W-1:0]   j, k_sel, n_last;
    logic               mv, active, acc, seed, upd;
    logic signed [32:0] diff, in_x, ema_x;
    logic [PRICE_W-1:0] macd;
    logic [SUM_W-1:0]   sum_x;
    logic               sum_sx;
    logic signed [41:0] prod_mul;
    logic [8:0]         n_plus;
    logic [NUM_W-1:0]   num_seed, num_upd, num;
    logic [DEN_W-1:0]   den;
    logic [DIV_W-1:0]   dividend, quot;
    logic [NUM_W-1:0]   res;
    logic [PRICE_W-1:0] sig_sat;
    logic               div_done;
    logic               fv, gv;

    macd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (den),
        .done     (div_done),
        .quotient (quot)
    );

    always_comb begin
        fd = (fast_days_reg == '0) ? 8'd1 : fast_days_reg;
        sd = (slow_days_reg == '0) ? 8'd1 : slow_days_reg;
        gd = (signal_days_reg == '0) ? 8'd1 : signal_days_reg;
        ms = ((fd > sd) ? fd : sd) - 8'd1;
        mv = index_reg >= {8'd0, ms};
        j  = index_reg - {8'd0, ms};

        // fast minus slow, clamped to the signed price range
        diff = $signed({1'b0, fast_ema_reg}) - $signed({1'b0, slow_ema_reg});
        if (diff[32] != diff[31]) begin
            macd = diff[32] ? {1'b1, {(PRICE_W-1){1'b0}}} : {1'b0, {(PRICE_W-1){1'b1}}};
        end else begin
            macd = diff[31:0];
        end

        case (cmd.unit)
            UNIT_FAST: begin
                n_sel  = fd;
                k_sel  = index_reg;
                active = 1'b1;
                in_x   = {1'b0, price_reg};
                ema_x  = {1'b0, fast_ema_reg};
                sum_x  = fast_sum_reg;
                sum_sx = 1'b0;
            end
            UNIT_SLOW: begin
                n_sel  = sd;
                k_sel  = index_reg;
                active = 1'b1;
                in_x   = {1'b0, price_reg};
                ema_x  = {1'b0, slow_ema_reg};
                sum_x  = slow_sum_reg;
                sum_sx = 1'b0;
            end
            default: begin
                n_sel  = gd;
                k_sel  = j;
                active = mv;
                in_x   = {macd[31], macd};
                ema_x  = {signal_ema_reg[31], signal_ema_reg};
                sum_x  = macd_sum_reg;
                sum_sx = macd_sum_reg[SUM_W-1];
            end
        endcase

        n_last = {8'd0, n_sel} - 16'd1;
        acc    = active && (k_sel < {8'd0, n_sel});
        seed   = active && (k_sel == n_last);
        upd    = active && (k_sel > n_last);
        n_plus = {1'b0, n_sel} + 9'd1;

        // seed: round(sum / n); update: round((2x + (n-1)ema) / (n+1))
        // price sums are unsigned, only the MACD sum carries a sign
        num_seed = {{2{sum_sx}}, sum_x, 1'b0} + {35'd0, n_sel};
        num_upd  = {{8{in_x[32]}}, in_x, 2'b00} + {prod_reg, 1'b0} + {34'd0, n_plus};
        num      = seed ? num_seed : num_upd;
        den      = seed ? {1'b0, n_sel, 1'b0} : {n_plus, 1'b0};
        // floor for negatives: floor(-a/d) = ~floor((a-1)/d)
        dividend = num[NUM_W-1] ? ~num[DIV_W-1:0] : num[DIV_W-1:0];

        res = neg_reg ? {1'b1, ~quot} : {1'b0, quot};
        if (res[NUM_W-1:31] != {(NUM_W-31){res[NUM_W-1]}}) begin
            sig_sat = res[NUM_W-1] ? {1'b1, {(PRICE_W-1){1'b0}}} : {1'b0, {(PRICE_W-1){1'b1}}};
        end else begin
            sig_sat = res[31:0];
        end

        fv = index_reg >= {8'd0, fd - 8'd1};
        gv = mv && (j >= {8'd0, gd - 8'd1});
    end

    assign prod_mul = $signed(ema_x) * $signed({1'b0, n_sel - 8'd1});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_days_reg   <= FAST_DAYS_RST;
            slow_days_reg   <= SLOW_DAYS_RST;
            signal_days_reg <= SIGNAL_DAYS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_FAST_DAYS:   fast_days_reg   <= cfg_wr_data;
                CFG_SLOW_DAYS:   slow_days_reg   <= cfg_wr_data;
                CFG_SIGNAL_DAYS: signal_days_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg      <= '0;
            fast_sum_reg   <= '0;
            slow_sum_reg   <= '0;
            macd_sum_reg   <= '0;
            fast_ema_reg   <= '0;
            slow_ema_reg   <= '0;
            signal_ema_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.load && s_data.series_start) begin
                index_reg      <= '0;
                fast_sum_reg   <= '0;
                slow_sum_reg   <= '0;
                macd_sum_reg   <= '0;
                fast_ema_reg   <= '0;
                slow_ema_reg   <= '0;
                signal_ema_reg <= '0;
            end
            if (cmd.mul && acc) begin
                case (cmd.unit)
                    UNIT_FAST: fast_sum_reg <= fast_sum_reg + {8'd0, price_reg};
                    UNIT_SLOW: slow_sum_reg <= slow_sum_reg + {8'd0, price_reg};
                    default:   macd_sum_reg <= macd_sum_reg + {{8{macd[31]}}, macd};
                endcase
            end
            if (cmd.write) begin
                case (cmd.unit)
                    UNIT_FAST: fast_ema_reg   <= res[31:0];
                    UNIT_SLOW: slow_ema_reg   <= res[31:0];
                    default:   signal_ema_reg <= sig_sat;
                endcase
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
                if (index_reg != {IDX_W{1'b1}}) begin
                    index_reg <= index_reg + 1'b1;
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            price_reg <= s_data.close_price;
        end
        if (cmd.mul) begin
            prod_reg <= prod_mul;
        end
        if (cmd.div_start) begin
            neg_reg <= num[NUM_W-1];
        end
        if (cmd.emit) begin
            out_reg.fast_average <= fv ? fast_ema_reg : '0;
            out_reg.fast_valid   <= fv;
            out_reg.slow_average <= (index_reg >= {8'd0, sd - 8'd1}) ? slow_ema_reg : '0;
            out_reg.slow_valid   <= index_reg >= {8'd0, sd - 8'd1};
            out_reg.macd_value   <= mv ? macd : '0;
            out_reg.signal_value <= gv ? signal_ema_reg : '0;
            out_reg.signal_valid <= gv;
        end
    end

    assign status.need_div = seed || upd;
    assign status.div_done = div_done;
    assign status.out_full = out_valid_reg && !m_ready;
    assign m_data          = out_reg;
    assign m_valid         = out_valid_reg;

endmodule
`default_nettype wire
